@@ sv/rbnh_pkg.sv @@
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared types and constants for the ray / box nearest-hit core.
// ----------------------------------------------------------------------------
package rbnh_pkg;

  localparam int ID_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 5;

  localparam logic [CFG_AW-3:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-3:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-3:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_AW-3:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_AW-3:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_AW-3:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_AW-3:0] REG_EPS      = 3'd6;

  localparam logic signed [31:0] DIR_X_RESET = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN     = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic [15:0]        object_id;
    logic               box_valid;
    logic               last_object;
  } rbnh_in_t;

  typedef struct packed {
    logic        hit_found;
    logic [15:0] nearest_id;
    logic [30:0] nearest_distance;
  } rbnh_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MERGE,
    ST_DECIDE
  } rbnh_state_t;

endpackage

@@ sv/ray_box_nearest_hit_core.sv @@
// ----------------------------------------------------------------------------
// ray_box_nearest_hit_core
// Slab test of a configured ray against a stream of boxes, nearest hit kept.
// ----------------------------------------------------------------------------
//  channel | ports                  | beat
//  in      | in_valid/in_ready      | one box, id, valid and last flags
//  out     | out_valid/out_ready    | hit flag, nearest id and distance
//  cfg     | APB psel..pready       | one 32-bit register write or read
// One box takes an accept, six serial divides on the shared divider (each a
// start cycle, one bit step per quotient bit and a done cycle), then merge
// and decide; a skipped box goes from accept straight to decide. Not ready
// while a box is in work; a last box holds in decide while the previous
// result still waits on out_ready. Reset restores the register defaults and
// clears the tracker.
module ray_box_nearest_hit_core import rbnh_pkg::*; #(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbnh_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rbnh_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 64'd1);

  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [15:0]        eps_r;

  rbnh_state_t st_r, st_nxt;
  rbnh_in_t    box_r;
  logic [2:0]  k_r;
  logic signed [31:0] t_r [6];
  logic signed [31:0] best_r;
  logic [15:0] bid_r;
  logic        any_r;
  logic signed [31:0] tmin_r, tmax_r;
  rbnh_out_t   res_r;
  logic        out_vld_r;

  logic        wr;
  logic [2:0]  ridx;
  logic [1:0]  ax;
  logic signed [31:0] corner;
  logic signed [32:0] num;
  logic        div_start, div_done;
  logic signed [31:0] quot;
  logic        slot_free, dec_go, res_load;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign ridx   = paddr[CFG_AW-1:2];

  always_comb begin
    case (ridx)
      REG_ORIGIN_X: prdata = org_r[0];
      REG_ORIGIN_Y: prdata = org_r[1];
      REG_ORIGIN_Z: prdata = org_r[2];
      REG_DIR_X:    prdata = dir_r[0];
      REG_DIR_Y:    prdata = dir_r[1];
      REG_DIR_Z:    prdata = dir_r[2];
      REG_EPS:      prdata = {16'd0, eps_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= DIR_X_RESET; dir_r[1] <= '0; dir_r[2] <= '0;
      eps_r    <= '0;
    end else if (wr) begin
      case (ridx)
        REG_ORIGIN_X: org_r[0] <= pwdata;
        REG_ORIGIN_Y: org_r[1] <= pwdata;
        REG_ORIGIN_Z: org_r[2] <= pwdata;
        REG_DIR_X:    dir_r[0] <= pwdata;
        REG_DIR_Y:    dir_r[1] <= pwdata;
        REG_DIR_Z:    dir_r[2] <= pwdata;
        REG_EPS:      eps_r    <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  // quotient k: axis k/2, min corner when k even
  always_comb begin
    ax = k_r[2:1];
    case (k_r)
      3'd0:    corner = box_r.box_min_x;
      3'd1:    corner = box_r.box_max_x;
      3'd2:    corner = box_r.box_min_y;
      3'd3:    corner = box_r.box_max_y;
      3'd4:    corner = box_r.box_min_z;
      default: corner = box_r.box_max_z;
    endcase
    num = 33'(corner) - 33'(org_r[ax]);
  end

  rbnh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num),
    .den(dir_r[ax]), .eps(eps_r), .done(div_done), .quot(quot)
  );

  // a last box may leave decide only when the result register is free
  assign slot_free = !out_vld_r || out_ready;
  assign dec_go    = !box_r.last_object || slot_free;
  assign res_load  = (st_r == ST_DECIDE) && box_r.last_object && slot_free;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = in_data.box_valid ? ST_START : ST_DECIDE;
      ST_START:  st_nxt = ST_DIV;
      ST_DIV:    if (div_done) st_nxt = (k_r == 3'd5) ? ST_MERGE : ST_START;
      ST_MERGE:  st_nxt = ST_DECIDE;
      ST_DECIDE: if (dec_go) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    div_start = (st_r == ST_START);
    out_valid = out_vld_r;
  end
  assign out_data = res_r;

  logic signed [31:0] lo0, lo1, lo2, hi0, hi1, hi2, mx, mn, hit_dist;
  logic hit, upd;
  always_comb begin
    lo0 = (t_r[0] < t_r[1]) ? t_r[0] : t_r[1];
    hi0 = (t_r[0] < t_r[1]) ? t_r[1] : t_r[0];
    lo1 = (t_r[2] < t_r[3]) ? t_r[2] : t_r[3];
    hi1 = (t_r[2] < t_r[3]) ? t_r[3] : t_r[2];
    lo2 = (t_r[4] < t_r[5]) ? t_r[4] : t_r[5];
    hi2 = (t_r[4] < t_r[5]) ? t_r[5] : t_r[4];
    mx  = (lo0 > lo1) ? lo0 : lo1;
    mx  = (mx > lo2) ? mx : lo2;
    mn  = (hi0 < hi1) ? hi0 : hi1;
    mn  = (mn < hi2) ? mn : hi2;
    hit      = !tmax_r[31] && !(tmin_r > tmax_r);
    hit_dist = tmin_r[31] ? tmax_r : tmin_r;
    upd      = box_r.box_valid && hit && (!any_r || hit_dist < best_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      any_r     <= 1'b0;
      best_r    <= SAT_MAX;
      bid_r     <= '0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (in_valid) k_r <= '0;
        ST_DIV: if (div_done) begin
          t_r[k_r] <= quot;
          k_r      <= k_r + 3'd1;
        end
        ST_MERGE: begin
          tmin_r <= mx;
          tmax_r <= mn;
        end
        ST_DECIDE: if (dec_go) begin
          if (box_r.last_object) begin
            any_r  <= 1'b0;
            best_r <= SAT_MAX;
            bid_r  <= '0;
          end else if (upd) begin
            best_r <= hit_dist;
            bid_r  <= box_r.object_id & ID_MASK;
            any_r  <= 1'b1;
          end
        end
        default: ;
      endcase
      if (res_load) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
    if (st_r == ST_IDLE && in_valid) box_r <= in_data;
    if (res_load) begin
      if (upd) begin
        res_r.hit_found        <= 1'b1;
        res_r.nearest_id       <= box_r.object_id & ID_MASK;
        res_r.nearest_distance <= hit_dist[30:0];
      end else begin
        res_r.hit_found        <= any_r;
        res_r.nearest_id       <= any_r ? bid_r : 16'd0;
        res_r.nearest_distance <= any_r ? best_r[30:0] : 31'd0;
      end
    end
  end

endmodule

@@ sv/rbnh_div.sv @@
// ----------------------------------------------------------------------------
// rbnh_div
// Signed saturating fixed-point quotient, restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module rbnh_div import rbnh_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  input  logic [15:0]        eps,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [32:0]   dm_r, dm_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [32:0] nm, dmag, trial;
  logic [33:0] sh;
  logic        dneg;

  always_comb begin
    nm    = num[32] ? 33'(-num) : 33'(num);
    dneg  = den[31];
    dmag  = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
    sh    = {rem_r, q_r[NW-1]};
    trial = sh[32:0] - dm_r;
    q_nxt = q_r; rem_nxt = rem_r; dm_nxt = dm_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      if (dmag <= {17'd0, eps}) begin
        dmag = 33'd1;
        dneg = 1'b0;
      end
      q_nxt    = {nm, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dm_nxt   = dmag;
      neg_nxt  = num[32] ^ dneg;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, sh} >= {2'b0, dm_r}) begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[32:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dm_r  <= dm_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      if (q_r > NW'(33'h0_8000_0000)) quot = SAT_MIN;
      else quot = 32'(-q_r);
    end else begin
      if (q_r > NW'(33'h0_7FFF_FFFF)) quot = SAT_MAX;
      else quot = 32'(q_r);
    end
  end

  assign done = done_r;

endmodule
